@@ hw/rtl/smss_pkg.sv @@
// Shared types and constants for the sorted matrix staircase search block.
// No dependencies; imported by the controller and the top level.
package smss_pkg;

  // Widths of the fixed interface fields.
  localparam int COUNT_W  = 5;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int APB_W    = 32;
  localparam int PADDR_W  = 3;

  // Default sizes of the matrix store.
  localparam int DEF_MAX_ROWS   = 16;
  localparam int DEF_MAX_COLS   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } smss_state_t;

endpackage

@@ hw/rtl/smss_mem.sv @@
// Matrix store: one write port and one read port, read data registered.
// No package dependencies.
module smss_mem #(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 256,
  parameter int AW         = 8
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic signed [DATA_WIDTH-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic signed [DATA_WIDTH-1:0] rd_data
);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/smss_ctrl.sv @@
// Request decode and staircase walk controller; drives the matrix store ports.
// Depends on smss_pkg for request codes, field widths and the state type.
module smss_ctrl #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int RCW        = 5,
  parameter int CCW1       = 5,
  parameter int AW         = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type,
  input  logic [smss_pkg::ROW_W-1:0]   entry_row,
  input  logic [smss_pkg::COL_W-1:0]   entry_col,
  input  logic signed [DATA_WIDTH-1:0] write_value,
  input  logic signed [DATA_WIDTH-1:0] target,
  input  logic [RCW-1:0]               rows_lim,
  input  logic [CCW1-1:0]              cols_lim,
  output logic                         res_valid,
  output logic                         res_found,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic signed [DATA_WIDTH-1:0] wr_data,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  input  logic signed [DATA_WIDTH-1:0] rd_data
);

  import smss_pkg::*;

  localparam int CCW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  smss_state_t                  state_r, state_nxt;
  logic [RCW-1:0]               row_r, row_nxt, row_inc;
  logic [CCW-1:0]               col_r, col_nxt;
  logic signed [DATA_WIDTH-1:0] tgt_r, tgt_nxt;
  logic                         valid_r, valid_nxt;
  logic                         found_r, found_nxt;
  logic                         take;

  assign busy    = (state_r == ST_WALK);
  assign take    = start && (state_r == ST_IDLE);
  assign row_inc = row_r + 1'b1;

  // Writes land in the store at the accepting edge; out-of-range entries drop.
  assign wr_en   = take && (req_type == REQ_WRITE)
                   && (32'(entry_row) < MAX_ROWS) && (32'(entry_col) < MAX_COLS);
  assign wr_addr = AW'(32'(entry_row) * MAX_COLS + 32'(entry_col));
  assign wr_data = write_value;

  // Next probe address comes straight from the next walk position.
  assign rd_addr = AW'(32'(row_nxt) * MAX_COLS + 32'(col_nxt));

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    tgt_nxt   = tgt_r;
    valid_nxt = 1'b0;
    found_nxt = found_r;
    rd_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (take && (req_type == REQ_QUERY)) begin
          if ((rows_lim == '0) || (cols_lim == '0)) begin
            valid_nxt = 1'b1;
            found_nxt = 1'b0;
          end else begin
            row_nxt   = '0;
            col_nxt   = CCW'(cols_lim - 1'b1);
            tgt_nxt   = target;
            rd_en     = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (rd_data == tgt_r) begin
          valid_nxt = 1'b1;
          found_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else if (rd_data < tgt_r) begin
          // probe too small: step down a row
          if (row_inc == rows_lim) begin
            valid_nxt = 1'b1;
            found_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            row_nxt = row_inc;
            rd_en   = 1'b1;
          end
        end else begin
          // probe too large: step left a column
          if (col_r == '0) begin
            valid_nxt = 1'b1;
            found_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            col_nxt = col_r - 1'b1;
            rd_en   = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    tgt_r   <= tgt_nxt;
    found_r <= found_nxt;
  end

  assign res_valid = valid_r;
  assign res_found = found_r;

endmodule

@@ hw/rtl/sorted_matrix_staircase_search.sv @@
// Top level: APB register file for the used area, walk controller and matrix store.
// Depends on smss_pkg, smss_ctrl and smss_mem.
//
// A write word (req_type 0) stores one entry; busy stays low.
// A query word (req_type 1) walks from the top-right corner of the used area,
// one probe per clock through the single read port of the matrix store, and it
// holds busy while it walks. out_valid pulses for exactly one cycle with
// out_found, in the cycle after the last probe (or in the cycle after start
// when the used area is empty); the receiver cannot stall it, so sample
// out_found whenever out_valid is high. A new word may start in the
// cycle the result is shown. Counts above the store size saturate to it.
// Entries are undefined until written; the store has no clearing pass.
module sorted_matrix_staircase_search #(
  parameter int MAX_ROWS   = smss_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = smss_pkg::DEF_MAX_COLS,
  parameter int DATA_WIDTH = smss_pkg::DEF_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic [smss_pkg::ROW_W-1:0]        in_entry_row,
  input  logic [smss_pkg::COL_W-1:0]        in_entry_col,
  input  logic signed [smss_pkg::VALUE_W-1:0] in_write_value,
  input  logic signed [smss_pkg::VALUE_W-1:0] in_target,
  output logic                              out_valid,
  output logic                              out_found,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [smss_pkg::PADDR_W-1:0]      paddr,
  input  logic [smss_pkg::APB_W-1:0]        pwdata,
  output logic [smss_pkg::APB_W-1:0]        prdata,
  output logic                              pready
);

  import smss_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW1  = $clog2(MAX_COLS + 1);

  logic [COUNT_W-1:0]           rows_r, cols_r;
  logic [RCW-1:0]               rows_lim;
  logic [CCW1-1:0]              cols_lim;
  logic                         cfg_wr;
  logic signed [DATA_WIDTH-1:0] wr_value_dw, target_dw;
  logic                         wr_en, rd_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic signed [DATA_WIDTH-1:0] wr_data, rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
      cols_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROWS_IN_USE: rows_r <= pwdata[COUNT_W-1:0];
        REG_COLS_IN_USE: cols_r <= pwdata[COUNT_W-1:0];
        default:         rows_r <= rows_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROWS_IN_USE: prdata = APB_W'(rows_r);
      REG_COLS_IN_USE: prdata = APB_W'(cols_r);
      default:         prdata = '0;
    endcase
  end

  // Saturate the used area to the store size.
  assign rows_lim = (32'(rows_r) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_r);
  assign cols_lim = (32'(cols_r) > MAX_COLS) ? CCW1'(MAX_COLS) : CCW1'(cols_r);

  // Narrow or sign-extend the 32-bit fields to the store width.
  assign wr_value_dw = DATA_WIDTH'(in_write_value);
  assign target_dw   = DATA_WIDTH'(in_target);

  smss_ctrl #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .DATA_WIDTH(DATA_WIDTH),
    .RCW       (RCW),
    .CCW1      (CCW1),
    .AW        (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req_type   (in_req_type),
    .entry_row  (in_entry_row),
    .entry_col  (in_entry_col),
    .write_value(wr_value_dw),
    .target     (target_dw),
    .rows_lim   (rows_lim),
    .cols_lim   (cols_lim),
    .res_valid  (out_valid),
    .res_found  (out_found),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  smss_mem #(
    .DATA_WIDTH(DATA_WIDTH),
    .DEPTH     (DEPTH),
    .AW        (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule
